// ===== rtl/pcm_bytes_to_float32_converter_unit_macros.svh =====
// assertion macros for the pcm byte to float32 converter
`ifndef PCM_BYTES_TO_FLOAT32_CONVERTER_UNIT_MACROS_SVH
`define PCM_BYTES_TO_FLOAT32_CONVERTER_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PBF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbf assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define PBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbf assertion failed");

`endif

// ===== rtl/pbf_pkg.sv =====
// shared types and constants for the pcm byte to float32 converter
package pbf_pkg;

   localparam int MaxChannelsDefault = 16;

   typedef enum logic [1:0] {
      ENC_PCM16   = 2'd0,
      ENC_PCM24   = 2'd1,
      ENC_PCM32   = 2'd2,
      ENC_FLOAT32 = 2'd3
   } encoding_type;

   typedef enum logic {
      CSR_ENCODING      = 1'b0,
      CSR_CHANNEL_COUNT = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/pcm_bytes_to_float32_converter_unit.sv =====
// pcm byte to float32 converter: top level
//
// req_ channel: one raw sample byte per transfer, little-endian, channels
//   interleaved; rsp_ channel: one result after the closing byte of a
//   sample (tdata binary32 sample, tuser channel index, tlast frame end)
// csr_ channel: encoding at index 0, channel count at index 1; any write
//   clears the byte and channel counters, write only while idle
// path: the closing byte is registered with its gathered bytes, the
//   conversion (leading-one search, shift, round) runs between that input
//   register and the result register, so a sample passes the input register
//   and then the result register, and a stalled result holds it in the first
// throughput: one byte per cycle; req_tready stays high unless both the
//   input and result registers are full and the result is stalled
// reset: synchronous, active high; encoding pcm16, channel count 2,
//   counters cleared, no result pending
// stall: while rsp_tready is low the result holds, the next closing byte
//   fills the input register, then req_tready drops until the result goes
module pcm_bytes_to_float32_converter_unit #(
   parameter int MAX_CHANNELS = pbf_pkg::MaxChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sample_bits
   output logic [3:0]  rsp_tuser,   // [3:0] channel_index
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pbf_pkg::*;
   `include "pcm_bytes_to_float32_converter_unit_macros.svh"

   localparam logic [4:0] ChanLimit = (MAX_CHANNELS > 16) ? 5'd16 : 5'(MAX_CHANNELS);

   // configuration
   encoding_type enc_ff, enc_in;
   logic [4:0]   chan_cnt_ff, chan_cnt_in;
   logic         csr_fire;

   // gathering state
   logic [23:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic [3:0]  chan_ff, chan_in;

   // input stage (raw sample)
   logic        s1_vld_ff, s1_vld_in;
   logic [31:0] s1_raw_ff, s1_raw_in;
   encoding_type s1_enc_ff, s1_enc_in;
   logic [3:0]  s1_chan_ff, s1_chan_in;
   logic        s1_last_ff, s1_last_in;

   // result stage
   logic        r_vld_ff, r_vld_in;
   logic [31:0] r_data_ff, r_data_in;
   logic [3:0]  r_chan_ff, r_chan_in;
   logic        r_last_ff, r_last_in;

   logic req_fire, s1_move, r_free;
   logic [1:0] nbytes_m1;
   logic closing;
   logic [4:0] chans;
   logic [3:0] cur_chan;
   logic last_ch;
   logic [31:0] raw_word;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   assign r_free     = ~r_vld_ff | rsp_tready;
   assign s1_move    = s1_vld_ff & r_free;
   assign req_tready = ~s1_vld_ff | r_free;
   assign req_fire   = req_tvalid & req_tready;

   // sample length and channel bookkeeping
   always_comb begin
      case (enc_ff)
         ENC_PCM16: nbytes_m1 = 2'd1;
         ENC_PCM24: nbytes_m1 = 2'd2;
         default:   nbytes_m1 = 2'd3;
      endcase
      closing = (pos_ff == nbytes_m1);
      chans = (chan_cnt_ff == 5'd0) ? 5'd1 :
              (chan_cnt_ff > ChanLimit) ? ChanLimit : chan_cnt_ff;
      cur_chan = ({1'b0, chan_ff} >= chans) ? 4'd0 : chan_ff;
      last_ch  = ({1'b0, cur_chan} + 5'd1 >= chans);
      case (pos_ff)
         2'd0:    raw_word = {24'd0, req_tdata};
         2'd1:    raw_word = {16'd0, req_tdata, acc_ff[7:0]};
         2'd2:    raw_word = {8'd0, req_tdata, acc_ff[15:0]};
         default: raw_word = {req_tdata, acc_ff[23:0]};
      endcase
   end

   // gathering and config next state
   always_comb begin
      enc_in = enc_ff;
      chan_cnt_in = chan_cnt_ff;
      acc_in = acc_ff;
      pos_in = pos_ff;
      chan_in = chan_ff;
      if (csr_fire) begin
         case (csr_index_type'(csr_index))
            CSR_ENCODING:      enc_in = encoding_type'(csr_data[1:0]);
            CSR_CHANNEL_COUNT: chan_cnt_in = csr_data[4:0];
            default:           enc_in = enc_ff;
         endcase
         acc_in = 24'd0;
         pos_in = 2'd0;
         chan_in = 4'd0;
      end else if (req_fire) begin
         if (closing) begin
            acc_in = 24'd0;
            pos_in = 2'd0;
            chan_in = last_ch ? 4'd0 : cur_chan + 4'd1;
         end else begin
            acc_in = raw_word[23:0];
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   // input stage next state
   always_comb begin
      s1_vld_in = s1_vld_ff & ~s1_move;
      s1_raw_in = s1_raw_ff;
      s1_enc_in = s1_enc_ff;
      s1_chan_in = s1_chan_ff;
      s1_last_in = s1_last_ff;
      if (req_fire && closing) begin
         s1_vld_in = 1'b1;
         s1_raw_in = raw_word;
         s1_enc_in = enc_ff;
         s1_chan_in = cur_chan;
         s1_last_in = last_ch;
      end
   end

   // pcm to binary32 conversion
   logic [31:0] conv;
   logic [31:0] ext, mag;
   logic        neg;
   logic [4:0]  lead;
   logic [31:0] norm;
   logic        rnd_up;
   logic [24:0] q;
   logic [7:0]  expo, bias;
   always_comb begin
      case (s1_enc_ff)
         ENC_PCM16: begin
            ext = {{16{s1_raw_ff[15]}}, s1_raw_ff[15:0]};
            bias = 8'd112;
         end
         ENC_PCM24: begin
            ext = {{8{s1_raw_ff[23]}}, s1_raw_ff[23:0]};
            bias = 8'd104;
         end
         default: begin
            ext = s1_raw_ff;
            bias = 8'd96;
         end
      endcase
      neg = ext[31];
      mag = neg ? (32'd0 - ext) : ext;
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) lead = 5'(i);
      end
      norm = mag << (5'd31 - lead);
      // norm[31] leading one, [30:8] fraction, [7] guard, [6:0] sticky
      rnd_up = norm[7] & ((|norm[6:0]) | norm[8]);
      q = {1'b0, norm[31:8]} + {24'd0, rnd_up};
      expo = {3'd0, lead} + bias;
      if (q[24]) begin
         expo = expo + 8'd1;
      end
      if (mag == 32'd0) begin
         conv = 32'd0;
      end else begin
         conv = {neg, expo, q[24] ? q[23:1] : q[22:0]};
      end
   end

   // result stage next state
   always_comb begin
      r_vld_in = r_vld_ff & ~rsp_tready;
      r_data_in = r_data_ff;
      r_chan_in = r_chan_ff;
      r_last_in = r_last_ff;
      if (s1_move) begin
         r_vld_in = 1'b1;
         r_data_in = (s1_enc_ff == ENC_FLOAT32) ? s1_raw_ff : conv;
         r_chan_in = s1_chan_ff;
         r_last_in = s1_last_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff <= ENC_PCM16;
         chan_cnt_ff <= 5'd2;
         acc_ff <= 24'd0;
         pos_ff <= 2'd0;
         chan_ff <= 4'd0;
         s1_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
      end else begin
         enc_ff <= enc_in;
         chan_cnt_ff <= chan_cnt_in;
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         chan_ff <= chan_in;
         s1_vld_ff <= s1_vld_in;
         r_vld_ff <= r_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_raw_ff <= s1_raw_in;
      s1_enc_ff <= s1_enc_in;
      s1_chan_ff <= s1_chan_in;
      s1_last_ff <= s1_last_in;
      r_data_ff <= r_data_in;
      r_chan_ff <= r_chan_in;
      r_last_ff <= r_last_in;
   end

   assign rsp_tvalid = r_vld_ff;
   assign rsp_tdata  = r_data_ff;
   assign rsp_tuser  = r_chan_ff;
   assign rsp_tlast  = r_last_ff;

   // checks
   `PBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `PBF_ASSERT_IMPL(a_pos_range, clock, reset, 1'b1, pos_ff <= nbytes_m1)
   `PBF_ASSERT_IMPL(a_chan_range, clock, reset, 1'b1,
      {1'b0, chan_ff} < chans || chan_ff == 4'd0 || csr_fire || $past(csr_fire))
   `PBF_ASSERT_IMPL(a_tlast_chan, clock, reset,
      rsp_tvalid && rsp_tuser != 4'd0 && !$past(csr_fire),
      rsp_tlast || rsp_tuser != 4'd15)
endmodule

// ===== sim/tb_pcm_bytes_to_float32_converter_unit.sv =====
// self-checking testbench for the pcm byte to float32 converter unit
`timescale 1ns / 1ps

module tb_pcm_bytes_to_float32_converter_unit;
   import pbf_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int SettleTicks = 8;
   localparam int ReportMax   = 10;

   typedef struct packed {
      logic [31:0] sample_bits;
      logic [3:0]  channel_index;
      logic        frame_end;
   } sample_result_type;

   typedef struct {
      encoding_type enc;
      logic [4:0]   chans;
      logic [31:0]  raw;
      logic [31:0]  known_bits;
      bit           known;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor state
   encoding_type      cur_enc;
   logic [4:0]        cur_chans;
   logic [23:0]       byte_acc;
   logic [1:0]        byte_pos;
   logic [3:0]        chan_pos;
   sample_result_type pending_samples[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  quiet_phase = 1'b0;
   directed_row_type dir_tab[20];

   pcm_bytes_to_float32_converter_unit uut (.*);

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("pcm_bytes_to_float32_converter_unit regression: fail");
         $finish;
      end
   end

   function automatic int unsigned sample_byte_count(encoding_type enc);
      case (enc)
         ENC_PCM16: return 2;
         ENC_PCM24: return 3;
         default:   return 4;
      endcase
   endfunction

   // signed pcm scaled to binary32, round to nearest even
   function automatic logic [31:0] pcm_to_single(logic [31:0] raw, int unsigned nb);
      int unsigned width, p, s;
      logic [31:0] mask, mag, rem, half, q, frac, expo;
      logic        neg;
      width = nb * 8;
      mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
      raw = raw & mask;
      neg = raw[width - 1];
      mag = neg ? ((32'd0 - raw) & mask) : raw;
      if (mag == 0) return 32'd0;
      p = 31;
      while (mag[p] == 1'b0) p--;
      if (p <= 23) begin
         frac = (mag << (23 - p)) & 32'h7F_FFFF;
      end else begin
         s = p - 23;
         rem = mag & ((32'd1 << s) - 1);
         half = 32'd1 << (s - 1);
         q = mag >> s;
         if (rem > half || (rem == half && q[0])) q = q + 1;
         if (q[24]) begin
            q = q >> 1;
            p++;
         end
         frac = q & 32'h7F_FFFF;
      end
      expo = p + 127 - (width - 1);
      return {neg, expo[7:0], frac[22:0]};
   endfunction

   // advance the predictor by one byte; returns 1 when a sample completes
   function automatic bit predict_byte(logic [7:0] b, output sample_result_type res);
      int unsigned nb, eff;
      logic [31:0] raw;
      nb = sample_byte_count(cur_enc);
      if (byte_pos + 1 < nb) begin
         byte_acc = byte_acc | (24'(b) << (8 * byte_pos));
         byte_pos = byte_pos + 2'd1;
         return 1'b0;
      end
      raw = {8'd0, byte_acc} | (32'(b) << (8 * byte_pos));
      byte_acc = '0;
      byte_pos = '0;
      res.sample_bits = (cur_enc == ENC_FLOAT32) ? raw : pcm_to_single(raw, nb);
      // zero channels act as one, above sixteen saturate
      eff = (cur_chans == 0) ? 1 : (cur_chans > 16) ? 16 : cur_chans;
      if (chan_pos >= eff) chan_pos = '0;
      res.channel_index = chan_pos;
      res.frame_end = (chan_pos + 1 >= eff);
      chan_pos = res.frame_end ? 4'd0 : chan_pos + 4'd1;
      return 1'b1;
   endfunction

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= ReportMax)
         $display("mismatch %s: expected %h actual %h", what, want, got);
   endtask

   // result checker and receiver stall bursts
   always @(posedge clock) begin
      sample_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            note_mismatch("unexpected result", 32'd0, rsp_tdata);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata !== want.sample_bits)
               note_mismatch("sample_bits", want.sample_bits, rsp_tdata);
            if (rsp_tuser !== want.channel_index)
               note_mismatch("channel_index", 32'(want.channel_index), 32'(rsp_tuser));
            if (rsp_tlast !== want.frame_end)
               note_mismatch("frame_end", 32'(want.frame_end), 32'(rsp_tlast));
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic wait_idle();
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   // register write; any write clears the byte and channel counters
   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ENCODING) cur_enc = encoding_type'(value[1:0]);
      else cur_chans = value[4:0];
      byte_acc = '0;
      byte_pos = '0;
      chan_pos = '0;
   endtask

   // one byte transfer with optional idle burst before it
   task automatic send_byte(logic [7:0] b, output bit done, output sample_result_type res);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      done = predict_byte(b, res);
      if (done) pending_samples.push_back(res);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      sample_result_type res;
      bit done;
      int unsigned nb, n_bytes;
      logic [4:0] chans;

      // directed stimulus: extremes per encoding and channel count corners
      dir_tab[0]  = '{ENC_PCM16,   5'd2,  32'h0000_0000, 32'h0000_0000, 1'b1};
      dir_tab[1]  = '{ENC_PCM16,   5'd2,  32'h0000_7FFF, 32'h3F7F_FE00, 1'b1};
      dir_tab[2]  = '{ENC_PCM16,   5'd2,  32'h0000_8000, 32'hBF80_0000, 1'b1};
      dir_tab[3]  = '{ENC_PCM16,   5'd2,  32'h0000_0001, 32'h3800_0000, 1'b1};
      dir_tab[4]  = '{ENC_PCM16,   5'd2,  32'h0000_FFFF, 32'hB800_0000, 1'b1};
      dir_tab[5]  = '{ENC_PCM24,   5'd1,  32'h0080_0000, 32'hBF80_0000, 1'b1};
      dir_tab[6]  = '{ENC_PCM24,   5'd1,  32'h007F_FFFF, 32'h3F7F_FFFE, 1'b1};
      dir_tab[7]  = '{ENC_PCM24,   5'd1,  32'h0000_0001, 32'h3400_0000, 1'b1};
      dir_tab[8]  = '{ENC_PCM24,   5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1};
      dir_tab[9]  = '{ENC_PCM24,   5'd0,  32'h0012_3456, 32'h0,         1'b0};
      dir_tab[10] = '{ENC_PCM32,   5'd16, 32'h7FFF_FFFF, 32'h3F80_0000, 1'b1};
      dir_tab[11] = '{ENC_PCM32,   5'd16, 32'h8000_0000, 32'hBF80_0000, 1'b1};
      dir_tab[12] = '{ENC_PCM32,   5'd16, 32'h0000_0001, 32'h3000_0000, 1'b1};
      dir_tab[13] = '{ENC_PCM32,   5'd16, 32'h0100_0001, 32'h0,         1'b0};
      dir_tab[14] = '{ENC_PCM32,   5'd17, 32'h0300_0002, 32'h0,         1'b0};
      dir_tab[15] = '{ENC_PCM32,   5'd17, 32'h0000_0000, 32'h0000_0000, 1'b1};
      dir_tab[16] = '{ENC_FLOAT32, 5'd31, 32'h7FC0_0000, 32'h7FC0_0000, 1'b1};
      dir_tab[17] = '{ENC_FLOAT32, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
      dir_tab[18] = '{ENC_FLOAT32, 5'd3,  32'h8000_0000, 32'h8000_0000, 1'b1};
      dir_tab[19] = '{ENC_FLOAT32, 5'd3,  32'h0000_0000, 32'h0000_0000, 1'b1};

      // reset state of the predictor
      cur_enc = ENC_PCM16;
      cur_chans = 5'd2;
      byte_acc = '0;
      byte_pos = '0;
      chan_pos = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].enc != cur_enc) begin
            end_burst();
            write_csr(CSR_ENCODING, 32'(dir_tab[i].enc));
         end
         if (dir_tab[i].chans != cur_chans) begin
            end_burst();
            write_csr(CSR_CHANNEL_COUNT, 32'(dir_tab[i].chans));
         end
         nb = sample_byte_count(dir_tab[i].enc);
         for (int k = 0; k < nb; k++) send_byte(dir_tab[i].raw[8*k +: 8], done, res);
         if (dir_tab[i].known && res.sample_bits !== dir_tab[i].known_bits)
            note_mismatch("directed sample", dir_tab[i].known_bits, res.sample_bits);
      end
      end_burst();

      // random phases; the last one runs without idling
      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 9) quiet_phase = 1'b1;
         case ($urandom_range(0, 5))
            0: chans = 5'd1;
            1: chans = 5'd16;
            2: chans = 5'd0;
            3: chans = 5'd31;
            default: chans = 5'($urandom);
         endcase
         write_csr(CSR_ENCODING, 32'($urandom_range(0, 3)));
         write_csr(CSR_CHANNEL_COUNT, {$urandom} & 32'hFFFF_FFE0 | 32'(chans));
         n_bytes = $urandom_range(40, 60);
         for (int k = 0; k < n_bytes; k++) begin
            send_byte(random_byte(), done, res);
            // sender holds off until the pipeline drains
            if (ph == 4 && k == n_bytes / 2) begin
               end_burst();
               while (pending_samples.size() != 0) @(posedge clock);
            end
         end
         end_burst();
      end

      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
      if (mismatch_count == 0)
         $display("pcm_bytes_to_float32_converter_unit regression: pass");
      else
         $display("pcm_bytes_to_float32_converter_unit regression: fail");
      $finish;
   end

endmodule
